FILE: rtl/fpa_pkg.sv
// shared constants and types for the fixed-partition first-fit allocator
package fpa_pkg;

    localparam int NUM_PARTS  = 4;
    localparam int SIZE_BITS  = 16;
    localparam int FRAG_BITS  = 18;
    localparam int IDX_W      = 2;
    localparam int PID_W      = 8;
    localparam int CNT_W      = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PART_COUNT = 3'd0;
    localparam int                    CFG_SIZE_BASE  = 1;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [CNT_W-1:0] PART_COUNT_RST = 3'd4;

    typedef logic [SIZE_BITS-1:0] t_size;
    typedef logic [FRAG_BITS-1:0] t_frag;

    // outcome of the first-fit search
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_fit;

    // fragmentation totals
    typedef struct packed {
        t_frag ext;
        t_frag intl;
    } t_frag_sum;

endpackage

FILE: rtl/fpa_fit_search.sv
// first-fit priority pick over the partitions
module fpa_fit_search (
    input  logic [fpa_pkg::NUM_PARTS-1:0] i_active,
    input  logic [fpa_pkg::NUM_PARTS-1:0] i_occupied,
    input  fpa_pkg::t_size                i_size [fpa_pkg::NUM_PARTS],
    input  fpa_pkg::t_size                i_req,
    output fpa_pkg::t_fit                 o_fit
);

    logic [fpa_pkg::NUM_PARTS-1:0] fits;

    always_comb begin
        for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
            fits[i] = i_active[i] && !i_occupied[i] && (i_size[i] >= i_req);
        end
    end

    // walk from the top so the lowest fitting partition wins
    always_comb begin
        o_fit.hit = 1'b0;
        o_fit.idx = '0;
        for (int i = fpa_pkg::NUM_PARTS - 1; i >= 0; i--) begin
            if (fits[i]) begin
                o_fit.hit = 1'b1;
                o_fit.idx = fpa_pkg::IDX_W'(i);
            end
        end
    end

endmodule

FILE: rtl/fpa_frag_sum.sv
// external and internal fragmentation totals over the active partitions
module fpa_frag_sum (
    input  logic [fpa_pkg::NUM_PARTS-1:0] i_active,
    input  logic [fpa_pkg::NUM_PARTS-1:0] i_occupied,
    input  fpa_pkg::t_size                i_size [fpa_pkg::NUM_PARTS],
    input  fpa_pkg::t_size                i_used [fpa_pkg::NUM_PARTS],
    output fpa_pkg::t_frag_sum            o_sum
);

    fpa_pkg::t_size used_eff [fpa_pkg::NUM_PARTS];
    fpa_pkg::t_size slack    [fpa_pkg::NUM_PARTS];
    fpa_pkg::t_size free_sz  [fpa_pkg::NUM_PARTS];

    always_comb begin
        for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
            used_eff[i] = i_occupied[i] ? i_used[i] : '0;
            // a shrunk partition below its used size adds nothing
            slack[i]    = (i_active[i] && (i_size[i] > used_eff[i]))
                          ? (i_size[i] - used_eff[i]) : '0;
            free_sz[i]  = (i_active[i] && !i_occupied[i]) ? i_size[i] : '0;
        end
    end

    // totals wrap at the frag width
    always_comb begin
        o_sum.ext  = '0;
        o_sum.intl = '0;
        for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
            o_sum.ext  = o_sum.ext  + fpa_pkg::FRAG_BITS'(free_sz[i]);
            o_sum.intl = o_sum.intl + fpa_pkg::FRAG_BITS'(slack[i]);
        end
    end

endmodule

FILE: rtl/fixed_partition_first_fit_allocator_top.sv
// top level of the fixed-partition first-fit allocator
//
// fixed-partition allocator with first fit. an allocate transaction
// (action 0) is granted the lowest-numbered free active partition whose
// configured size is at least request_size; the partition is marked
// occupied with process_id as holder and request_size as used size. a free
// transaction (action 1) clears the named partition, whether it was held or
// not, and always reports no grant. every transaction yields exactly one
// result carrying the grant, the granted index (0 when none) and the
// external and internal fragmentation totals as they stand after that
// transaction, both wrapping at 18 bits. partition i is active when
// i < part_count; inactive partitions keep their state but are neither
// searched nor summed. timing: an accepted transaction is held in the
// input register, where the search, state update and totals are done
// in a single pass, and its result moves into the output register as it
// advances; a new transaction is taken every cycle while results are
// drained. the output register is the only thing that throttles input:
// a held result stalls the input register only while it cannot move on.
// configuration registers (index 0 part_count, 1..4 partition sizes)
// are written through a plain write port and must only change while the
// block is idle; other indexes are ignored.
module fixed_partition_first_fit_allocator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_action,
    input  logic [fpa_pkg::SIZE_BITS-1:0]    i_request_size,
    input  logic [fpa_pkg::PID_W-1:0]        i_process_id,
    input  logic [fpa_pkg::IDX_W-1:0]        i_partition_index,

    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_granted,
    output logic [fpa_pkg::IDX_W-1:0]        o_granted_index,
    output logic [fpa_pkg::FRAG_BITS-1:0]    o_external_frag,
    output logic [fpa_pkg::FRAG_BITS-1:0]    o_internal_frag,

    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [fpa_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    // configuration registers
    logic [fpa_pkg::CNT_W-1:0] r_part_count;
    fpa_pkg::t_size            r_size [fpa_pkg::NUM_PARTS];

    // per-partition state
    logic [fpa_pkg::NUM_PARTS-1:0] r_occupied, n_occupied;
    logic [fpa_pkg::PID_W-1:0]     r_holder [fpa_pkg::NUM_PARTS];
    logic [fpa_pkg::PID_W-1:0]     n_holder [fpa_pkg::NUM_PARTS];
    fpa_pkg::t_size                r_used   [fpa_pkg::NUM_PARTS];
    fpa_pkg::t_size                n_used   [fpa_pkg::NUM_PARTS];

    // input register
    logic                          r_in_vld;
    logic                          r_action;
    fpa_pkg::t_size                r_req;
    logic [fpa_pkg::PID_W-1:0]     r_pid;
    logic [fpa_pkg::IDX_W-1:0]     r_pidx;

    // result register
    logic                          r_out_vld;
    logic                          r_granted;
    logic [fpa_pkg::IDX_W-1:0]     r_gidx;
    fpa_pkg::t_frag                r_ext;
    fpa_pkg::t_frag                r_intl;

    logic [fpa_pkg::NUM_PARTS-1:0] active;
    logic                          advance;
    logic                          do_grant;
    fpa_pkg::t_fit                 fit;
    fpa_pkg::t_frag_sum            sums;

    // the staged transaction moves on when the result slot is free or drains
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_comb begin
        for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
            active[i] = (32'(r_part_count) > i);
        end
    end

    fpa_fit_search u_search (
        .i_active   (active),
        .i_occupied (r_occupied),
        .i_size     (r_size),
        .i_req      (r_req),
        .o_fit      (fit)
    );

    assign do_grant = (r_action == fpa_pkg::ACT_ALLOC) && fit.hit;

    // state after the staged transaction
    always_comb begin
        n_occupied = r_occupied;
        n_holder   = r_holder;
        n_used     = r_used;
        if (r_action == fpa_pkg::ACT_ALLOC) begin
            if (fit.hit) begin
                n_occupied[fit.idx] = 1'b1;
                n_holder[fit.idx]   = r_pid;
                n_used[fit.idx]     = r_req;
            end
        end else if (32'(r_pidx) < fpa_pkg::NUM_PARTS) begin
            n_occupied[r_pidx] = 1'b0;
            n_holder[r_pidx]   = '0;
            n_used[r_pidx]     = '0;
        end
    end

    // totals are taken over the updated state
    fpa_frag_sum u_frag (
        .i_active   (active),
        .i_occupied (n_occupied),
        .i_size     (r_size),
        .i_used     (n_used),
        .o_sum      (sums)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part_count <= fpa_pkg::PART_COUNT_RST;
            for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
                r_size[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_addr == fpa_pkg::CFG_PART_COUNT) begin
                r_part_count <= i_cfg_wdata[fpa_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
                if (i_cfg_addr == fpa_pkg::CFG_ADDR_W'(fpa_pkg::CFG_SIZE_BASE + i)) begin
                    r_size[i] <= i_cfg_wdata[fpa_pkg::SIZE_BITS-1:0];
                end
            end
        end
    end

    // partition state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied <= '0;
            for (int i = 0; i < fpa_pkg::NUM_PARTS; i++) begin
                r_holder[i] <= '0;
                r_used[i]   <= '0;
            end
        end else if (advance) begin
            r_occupied <= n_occupied;
            r_holder   <= n_holder;
            r_used     <= n_used;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_req    <= i_request_size;
            r_pid    <= i_process_id;
            r_pidx   <= i_partition_index;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_granted <= do_grant;
            r_gidx    <= do_grant ? fit.idx : '0;
            r_ext     <= sums.ext;
            r_intl    <= sums.intl;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_granted       = r_granted;
    assign o_granted_index = r_gidx;
    assign o_external_frag = r_ext;
    assign o_internal_frag = r_intl;

endmodule

FILE: dv/fpa_alloc_checker.sv
// result checker for the first-fit partition allocator: predicts and compares every result
module fpa_alloc_checker
    import fpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_action,
    input  t_size                 i_request_size,
    input  logic [PID_W-1:0]      i_process_id,
    input  logic [IDX_W-1:0]      i_partition_index,

    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_granted,
    input  logic [IDX_W-1:0]      i_granted_index,
    input  t_frag                 i_external_frag,
    input  t_frag                 i_internal_frag,

    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,

    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] idx;
        t_frag            ext;
        t_frag            intl;
    } alloc_result_t;

    // shadow configuration
    logic [CNT_W-1:0] cfg_count;
    t_size            cfg_size [NUM_PARTS];

    // shadow partition table
    logic             part_busy  [NUM_PARTS];
    logic [PID_W-1:0] part_owner [NUM_PARTS];
    t_size            part_used  [NUM_PARTS];

    alloc_result_t    expected_results [$];
    int               mismatches = 0;

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // applies one transaction to the shadow table and returns the result it must produce
    function automatic alloc_result_t step_allocator(input logic act, input t_size req,
                                                     input logic [PID_W-1:0] pid,
                                                     input logic [IDX_W-1:0] pidx);
        alloc_result_t r;
        int            lim;
        int            i;
        t_size         used;
        r   = '0;
        lim = (cfg_count > NUM_PARTS) ? NUM_PARTS : int'(cfg_count);
        if (act == ACT_ALLOC) begin
            for (i = 0; i < lim; i++) begin
                if (!r.granted && !part_busy[i] && cfg_size[i] >= req) begin
                    part_busy[i]  = 1'b1;
                    part_owner[i] = pid;
                    part_used[i]  = req;
                    r.granted     = 1'b1;
                    r.idx         = IDX_W'(i);
                end
            end
        end else begin
            // inactive or already free partitions are cleared the same way
            part_busy[pidx]  = 1'b0;
            part_owner[pidx] = '0;
            part_used[pidx]  = '0;
        end
        for (i = 0; i < lim; i++) begin
            used = part_busy[i] ? part_used[i] : '0;
            if (!part_busy[i])
                r.ext = r.ext + t_frag'(cfg_size[i]);
            if (cfg_size[i] > used)
                r.intl = r.intl + t_frag'(cfg_size[i] - used);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        alloc_result_t want;
        int            k;
        if (!i_rst_n) begin
            cfg_count = PART_COUNT_RST;
            for (k = 0; k < NUM_PARTS; k++) begin
                cfg_size[k]   = '0;
                part_busy[k]  = 1'b0;
                part_owner[k] = '0;
                part_used[k]  = '0;
            end
            expected_results.delete();
        end else begin
            // compare before pushing: a result never leaves in its own acceptance cycle
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    log_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (i_granted !== want.granted)
                        log_mismatch($sformatf("granted got %0d expected %0d",
                                               i_granted, want.granted));
                    if (i_granted_index !== want.idx)
                        log_mismatch($sformatf("granted_index got %0d expected %0d",
                                               i_granted_index, want.idx));
                    if (i_external_frag !== want.ext)
                        log_mismatch($sformatf("external_frag got %0d expected %0d",
                                               i_external_frag, want.ext));
                    if (i_internal_frag !== want.intl)
                        log_mismatch($sformatf("internal_frag got %0d expected %0d",
                                               i_internal_frag, want.intl));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(step_allocator(i_action, i_request_size,
                                                          i_process_id, i_partition_index));
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_PART_COUNT)
                    cfg_count = i_cfg_wdata[CNT_W-1:0];
                else if (i_cfg_addr >= CFG_SIZE_BASE && i_cfg_addr < CFG_SIZE_BASE + NUM_PARTS)
                    cfg_size[i_cfg_addr - CFG_SIZE_BASE] = t_size'(i_cfg_wdata);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: dv/tb_fixed_partition_first_fit_allocator_top.sv
// testbench top for the first-fit partition allocator: stimulus, flow control and verdict
module tb_fixed_partition_first_fit_allocator_top;
    import fpa_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 66;
    // first register index past the size registers, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_UNUSED = CFG_ADDR_W'(CFG_SIZE_BASE + NUM_PARTS);

    // size picking styles for configuration
    typedef enum int {SZ_TINY, SZ_FULL, SZ_EXTREME, SZ_MIXED} size_style_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;

    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic                  action        = ACT_ALLOC;
    t_size                 request_size  = '0;
    logic [PID_W-1:0]      process_id    = '0;
    logic [IDX_W-1:0]      partition_idx = '0;

    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic                  granted;
    logic [IDX_W-1:0]      granted_index;
    t_frag                 external_frag;
    t_frag                 internal_frag;

    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

    int                    fail_count;
    int                    pending;

    // percent of cycles the sender holds off and the receiver stalls
    int                    gap_pct       = 0;
    int                    stall_pct     = 0;

    // copy of what was last loaded, used to aim requests at partition sizes
    logic [NUM_PARTS-1:0][SIZE_BITS-1:0] cur_sizes = '0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    fixed_partition_first_fit_allocator_top u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_action          (action),
        .i_request_size    (request_size),
        .i_process_id      (process_id),
        .i_partition_index (partition_idx),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_granted         (granted),
        .o_granted_index   (granted_index),
        .o_external_frag   (external_frag),
        .o_internal_frag   (internal_frag),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata)
    );

    fpa_alloc_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_action          (action),
        .i_request_size    (request_size),
        .i_process_id      (process_id),
        .i_partition_index (partition_idx),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_granted         (granted),
        .i_granted_index   (granted_index),
        .i_external_frag   (external_frag),
        .i_internal_frag   (internal_frag),
        .i_cfg_we          (cfg_we),
        .i_cfg_addr        (cfg_addr),
        .i_cfg_wdata       (cfg_wdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one transaction on the input channel; returns at the edge that accepts it
    task automatic send_txn(input logic act, input t_size req,
                            input logic [PID_W-1:0] pid, input logic [IDX_W-1:0] pidx);
        // random hold-off before valid goes up
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        request_size  <= req;
        process_id    <= pid;
        partition_idx <= pidx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic alloc_req(input t_size req, input logic [PID_W-1:0] pid);
        send_txn(ACT_ALLOC, req, pid, IDX_W'($urandom()));
    endtask

    task automatic free_part(input logic [IDX_W-1:0] pidx);
        send_txn(ACT_FREE, t_size'($urandom()), PID_W'($urandom()), pidx);
    endtask

    // drop valid and wait until every expected result has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // writes part_count, all sizes and one unmapped index; only called while idle
    task automatic load_config(input logic [CNT_W-1:0] cnt,
                               input logic [NUM_PARTS-1:0][SIZE_BITS-1:0] sizes);
        int r;
        cur_sizes = sizes;
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_PART_COUNT;
        // upper data bits are junk that the count register has to mask off
        cfg_wdata <= {(CFG_DATA_W-CNT_W)'($urandom()), cnt};
        @(posedge clk);
        for (r = 0; r < NUM_PARTS; r++) begin
            cfg_addr  <= CFG_ADDR_W'(CFG_SIZE_BASE + r);
            cfg_wdata <= CFG_DATA_W'(sizes[r]);
            @(posedge clk);
        end
        cfg_addr  <= CFG_FIRST_UNUSED + CFG_ADDR_W'($urandom_range(0, 2));
        cfg_wdata <= CFG_DATA_W'($urandom());
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic t_size pick_size(input size_style_t style);
        t_size s;
        case (style)
            SZ_TINY:    s = t_size'($urandom_range(0, 255));
            SZ_FULL:    s = t_size'($urandom());
            SZ_EXTREME: s = ($urandom_range(1) != 0) ? '1 : '0;
            default: begin
                case ($urandom_range(3))
                    0:       s = t_size'($urandom_range(0, 255));
                    1:       s = ($urandom_range(1) != 0) ? '1 : '0;
                    default: s = t_size'($urandom());
                endcase
            end
        endcase
        return s;
    endfunction

    // random traffic: allocs partly aimed at a partition size boundary, frees of any slot
    task automatic random_txn;
        int    j;
        t_size req;
        j = $urandom_range(0, NUM_PARTS - 1);
        if ($urandom_range(99) < 55) begin
            case ($urandom_range(2))
                0:       req = t_size'(cur_sizes[j]) + t_size'($urandom_range(0, 2)) - t_size'(1);
                1:       req = t_size'($urandom_range(0, 255));
                default: req = t_size'($urandom());
            endcase
            alloc_req(req, PID_W'($urandom()));
        end else begin
            free_part(IDX_W'(j));
        end
    endtask

    initial begin
        int          p;
        int          n;
        int          q;
        size_style_t style;
        logic [CNT_W-1:0]                    cnt;
        logic [NUM_PARTS-1:0][SIZE_BITS-1:0] sizes;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sizes 100, 0, 65535, 50 with all four partitions active
        load_config(CNT_W'(4), {16'd50, 16'hFFFF, 16'd0, 16'd100});
        alloc_req(16'd0, 8'h00);          // zero request takes partition 0
        alloc_req(16'hFFFF, 8'hFF);       // largest request only fits partition 2
        alloc_req(16'd0, 8'h5A);          // zero-size partition fits a zero request
        alloc_req(16'd51, 8'h11);         // just over the last free size, no grant
        alloc_req(16'd50, 8'hA5);         // exact fit
        alloc_req(16'd1, 8'h22);          // everything held
        free_part(2'd0);
        free_part(2'd0);                  // freeing a free partition is harmless
        free_part(2'd3);
        alloc_req(16'd100, 8'h80);
        alloc_req(16'h8000, 8'h7F);
        drain();

        // shrink partition 0 under its used size; partitions 2 and 3 go inactive
        load_config(CNT_W'(2), {16'd50, 16'hFFFF, 16'd0, 16'd10});
        alloc_req(16'd5, 8'h01);
        free_part(2'd3);                  // clearing an inactive partition
        free_part(2'd1);
        alloc_req(16'd0, 8'h33);
        drain();

        // no active partition at all
        load_config(CNT_W'(0), {16'd50, 16'hFFFF, 16'd0, 16'd10});
        alloc_req(16'd0, 8'h44);
        free_part(2'd2);                  // inactive but occupied, cleared anyway
        drain();

        // count above the partition total, every size at maximum
        load_config(CNT_W'(7), {NUM_PARTS{16'hFFFF}});
        alloc_req(16'hFFFF, 8'h01);
        alloc_req(16'hFFFF, 8'h02);
        alloc_req(16'd0, 8'h03);
        free_part(2'd0);
        free_part(2'd1);
        free_part(2'd2);
        free_part(2'd3);
        drain();

        // random phases, cycling through the four idling modes
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cnt = CNT_W'(4); style = SZ_TINY;    end
                1: begin cnt = CNT_W'(1); style = SZ_FULL;    end
                2: begin cnt = CNT_W'(7); style = SZ_EXTREME; end
                3: begin cnt = CNT_W'(3); style = SZ_MIXED;   end
                4: begin cnt = CNT_W'(4); style = SZ_EXTREME; end
                5: begin cnt = CNT_W'(5); style = SZ_TINY;    end
                default: begin
                    cnt   = CNT_W'($urandom_range(0, 7));
                    style = SZ_MIXED;
                end
            endcase
            for (q = 0; q < NUM_PARTS; q++)
                sizes[q] = pick_size(style);
            load_config(cnt, sizes);

            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 61; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 61; end
                default: begin gap_pct = 37; stall_pct = 37; end
            endcase

            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_txn();
            drain();
            gap_pct   = 0;
            stall_pct = 0;
        end

        // let the pipeline settle before the verdict
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
